// ===== rtl/zssf_pkg.sv =====
package zssf_pkg;

  // zlib header bytes
  localparam logic [7:0] HdrCmf = 8'h78;
  localparam logic [7:0] HdrFlg = 8'h01;

  // largest stored block payload
  localparam logic [15:0] BlockMax = 16'hFFFF;

  // adler-32 modulus
  localparam logic [16:0] AdlerMod = 17'd65521;

  // depth of the command queue between front and back
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW = $clog2(QueueDepth);
  localparam int unsigned QCntW = $clog2(QueueDepth + 1);

  // one classified payload byte and the framing it needs
  typedef struct packed {
    logic        hdr;       // stream header goes first
    logic        blk;       // stored block head goes first
    logic        final_blk; // flag byte value
    logic [15:0] len;       // block length
    logic [7:0]  data;      // payload byte
    logic        trl;       // checksum follows
    logic [15:0] sum_hi;    // adler high sum after this byte
    logic [15:0] sum_lo;    // adler low sum after this byte
  } cmd_t;

endpackage

// ===== rtl/zssf_front.sv =====
module zssf_front import zssf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic [31:0] cfg_data_i,
  input  logic        accept_i,
  input  logic [7:0]  payload_byte_i,
  output cmd_t        cmd_o
);

  logic [31:0] stream_len_q;
  logic [31:0] rem_q, rem_d;
  logic [15:0] blk_left_q, blk_left_d;
  logic [15:0] lo_q, lo_d;
  logic [15:0] hi_q, hi_d;
  logic        hdr_sent_q, hdr_sent_d;

  logic [31:0] rem;
  logic [15:0] blk_left;
  logic [15:0] lo;
  logic [15:0] hi;
  logic        blk;
  logic [15:0] len;
  logic [16:0] lo_sum;
  logic [15:0] lo_n;
  logic [16:0] hi_sum;
  logic [15:0] hi_n;
  logic        trl;

  // state seen by this byte, reloaded at the start of a stream
  always_comb begin
    if (hdr_sent_q) begin
      rem      = rem_q;
      blk_left = blk_left_q;
      lo       = lo_q;
      hi       = hi_q;
    end else begin
      rem      = (stream_len_q == 32'd0) ? 32'd1 : stream_len_q;
      blk_left = 16'd0;
      lo       = 16'd1;
      hi       = 16'd0;
    end
  end

  // block head and length
  assign blk = (blk_left == 16'd0);
  assign len = (rem > {16'd0, BlockMax}) ? BlockMax : rem[15:0];

  // adler update, add then conditional subtract
  assign lo_sum = {1'b0, lo} + {9'd0, payload_byte_i};
  assign lo_n   = (lo_sum >= AdlerMod) ? 16'(lo_sum - AdlerMod) : lo_sum[15:0];
  assign hi_sum = {1'b0, hi} + {1'b0, lo_n};
  assign hi_n   = (hi_sum >= AdlerMod) ? 16'(hi_sum - AdlerMod) : hi_sum[15:0];

  assign trl = (rem == 32'd1);

  // command for the back part
  always_comb begin
    cmd_o.hdr       = !hdr_sent_q;
    cmd_o.blk       = blk;
    cmd_o.final_blk = (rem == {16'd0, len});
    cmd_o.len       = len;
    cmd_o.data      = payload_byte_i;
    cmd_o.trl       = trl;
    cmd_o.sum_hi    = hi_n;
    cmd_o.sum_lo    = lo_n;
  end

  // next stream state
  always_comb begin
    rem_d      = rem_q;
    blk_left_d = blk_left_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    hdr_sent_d = hdr_sent_q;
    if (accept_i) begin
      rem_d      = rem - 32'd1;
      blk_left_d = (blk ? len : blk_left) - 16'd1;
      lo_d       = lo_n;
      hi_d       = hi_n;
      hdr_sent_d = !trl;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stream_len_q <= 32'd1;
      rem_q        <= 32'd1;
      blk_left_q   <= 16'd0;
      lo_q         <= 16'd1;
      hi_q         <= 16'd0;
      hdr_sent_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        stream_len_q <= cfg_data_i;
      end
      rem_q      <= rem_d;
      blk_left_q <= blk_left_d;
      lo_q       <= lo_d;
      hi_q       <= hi_d;
      hdr_sent_q <= hdr_sent_d;
    end
  end

endmodule

// ===== rtl/zssf_queue.sv =====
module zssf_queue import zssf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  cmd_t wr_cmd_i,
  output logic full_o,
  input  logic rd_i,
  output cmd_t head_o,
  output logic empty_o
);

  cmd_t             mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q;
  logic [QPtrW-1:0] rd_ptr_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_wr;
  logic             do_rd;

  assign full_o  = (cnt_q == QCntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_cmd_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QueueDepth))
    else $error("queue level beyond depth");

endmodule

// ===== rtl/zssf_back.sv =====
module zssf_back import zssf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_t       head_i,
  input  logic       q_empty_i,
  output logic       q_rd_o,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  output logic       stream_done_o
);

  // emission phases of one command
  localparam logic [3:0] PhHdr0  = 4'd0;
  localparam logic [3:0] PhHdr1  = 4'd1;
  localparam logic [3:0] PhFlag  = 4'd2;
  localparam logic [3:0] PhLenLo = 4'd3;
  localparam logic [3:0] PhLenHi = 4'd4;
  localparam logic [3:0] PhNLnLo = 4'd5;
  localparam logic [3:0] PhNLnHi = 4'd6;
  localparam logic [3:0] PhData  = 4'd7;
  localparam logic [3:0] PhSumHh = 4'd8;
  localparam logic [3:0] PhSumHl = 4'd9;
  localparam logic [3:0] PhSumLh = 4'd10;
  localparam logic [3:0] PhSumLl = 4'd11;
  localparam logic [3:0] PhNone  = 4'd12;

  logic [3:0]  phase_q, phase_d;
  logic        started_q, started_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  byte_q;
  logic        last_q;
  logic        done_q;

  logic [3:0]  cur;
  logic [3:0]  nxt;
  logic [7:0]  sel_byte;
  logic [15:0] nlen;
  logic        advance;
  logic        last;

  assign nlen    = ~head_i.len;
  assign advance = !q_empty_i && (!out_valid_q || pop);

  // current phase, first one of the head command if not yet started
  always_comb begin
    if (started_q) begin
      cur = phase_q;
    end else if (head_i.hdr) begin
      cur = PhHdr0;
    end else if (head_i.blk) begin
      cur = PhFlag;
    end else begin
      cur = PhData;
    end
  end

  // phase sequencing and byte selection
  always_comb begin
    case (cur)
      PhHdr0:  begin nxt = PhHdr1;                         sel_byte = HdrCmf;              end
      PhHdr1:  begin nxt = head_i.blk ? PhFlag : PhData;   sel_byte = HdrFlg;              end
      PhFlag:  begin nxt = PhLenLo;  sel_byte = {7'd0, head_i.final_blk};                 end
      PhLenLo: begin nxt = PhLenHi;  sel_byte = head_i.len[7:0];                          end
      PhLenHi: begin nxt = PhNLnLo;  sel_byte = head_i.len[15:8];                         end
      PhNLnLo: begin nxt = PhNLnHi;  sel_byte = nlen[7:0];                                end
      PhNLnHi: begin nxt = PhData;   sel_byte = nlen[15:8];                               end
      PhData:  begin nxt = head_i.trl ? PhSumHh : PhNone;  sel_byte = head_i.data;         end
      PhSumHh: begin nxt = PhSumHl;  sel_byte = head_i.sum_hi[15:8];                      end
      PhSumHl: begin nxt = PhSumLh;  sel_byte = head_i.sum_hi[7:0];                       end
      PhSumLh: begin nxt = PhSumLl;  sel_byte = head_i.sum_lo[15:8];                      end
      PhSumLl: begin nxt = PhNone;   sel_byte = head_i.sum_lo[7:0];                       end
      default: begin nxt = PhNone;   sel_byte = 8'd0;                                     end
    endcase
  end

  assign last   = (nxt == PhNone);
  assign q_rd_o = advance && last;

  // sequencer state
  always_comb begin
    phase_d     = phase_q;
    started_d   = started_q;
    out_valid_d = out_valid_q && !pop;
    if (advance) begin
      out_valid_d = 1'b1;
      started_d   = !last;
      phase_d     = nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhHdr0;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      started_q   <= started_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (advance) begin
      byte_q <= sel_byte;
      last_q <= last;
      done_q <= (cur == PhSumLl);
    end
  end

  assign empty         = !out_valid_q;
  assign out_byte_o    = byte_q;
  assign run_last_o    = last_q;
  assign stream_done_o = done_q;

  a_started_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    started_q |-> !q_empty_i)
    else $error("command in progress but queue empty");

endmodule

// ===== rtl/zlib_stored_stream_framer_unit.sv =====
// path: a payload byte passes the command queue and the output register before it reaches the result side
// throughput: one output byte per cycle from the back sequencer unless stalled or idle;
//   a payload byte yields one to twelve output bytes (header, block head, byte, checksum)
// input: one byte per cycle while the four-entry command queue has room
// reset: asynchronous, clears queue, sequencer and stream state; length reads 1
module zlib_stored_stream_framer_unit import zssf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  payload_byte_i,
  input  logic        pop,
  output logic        empty,
  output logic [7:0]  out_byte_o,
  output logic        run_last_o,
  output logic        stream_done_o
);

  cmd_t cmd;
  cmd_t head;
  logic accept;
  logic q_empty;
  logic q_rd;

  assign cfg_ready_o = 1'b1;
  assign accept      = push && !full;

  // front: stream state, adler update, classification
  zssf_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .accept_i      (accept),
    .payload_byte_i(payload_byte_i),
    .cmd_o         (cmd)
  );

  // command queue
  zssf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (accept),
    .wr_cmd_i(cmd),
    .full_o  (full),
    .rd_i    (q_rd),
    .head_o  (head),
    .empty_o (q_empty)
  );

  // back: byte sequencer and output register
  zssf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .q_empty_i    (q_empty),
    .q_rd_o       (q_rd),
    .pop          (pop),
    .empty        (empty),
    .out_byte_o   (out_byte_o),
    .run_last_o   (run_last_o),
    .stream_done_o(stream_done_o)
  );

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && stream_done_o) |-> run_last_o)
    else $error("checksum end not marked as last");

endmodule

// ===== dv/zlib_stored_stream_framer_unit_test.sv =====
module zlib_stored_stream_framer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import zssf_pkg::*;

  // cycles without any transfer before the run is abandoned
  localparam int unsigned QuietLimit = 2000;
  // settling time after the last expected byte
  localparam int unsigned DrainCycles = 24;
  // size of the random part in payload bytes
  localparam int unsigned RandomBytes = 400;

  typedef struct {
    logic [7:0] out_byte;
    logic       run_last;
    logic       stream_done;
  } frame_byte_t;

  // predicts the zlib byte stream and checks the result side against it
  class zlib_frame_board;
    logic [31:0] length_reg;
    logic [31:0] bytes_left;
    logic [15:0] block_left;
    logic [16:0] sum_lo;
    logic [16:0] sum_hi;
    bit          in_stream;
    frame_byte_t step_bytes[$];
    frame_byte_t frame_due[$];
    int unsigned mismatches;

    function new();
      length_reg = 32'd1;
      bytes_left = 32'd1;
      block_left = '0;
      sum_lo     = 17'd1;
      sum_hi     = '0;
      in_stream  = 1'b0;
      mismatches = 0;
    endfunction

    function void emit_byte(logic [7:0] b, logic done);
      frame_byte_t fb;
      fb.out_byte    = b;
      fb.run_last    = 1'b0;
      fb.stream_done = done;
      step_bytes.push_back(fb);
    endfunction

    // one accepted payload byte: work out every byte it releases
    function void take_payload(logic [7:0] b);
      logic [31:0] len;
      step_bytes.delete();

      // new stream: latch the length, send the zlib header
      if (!in_stream) begin
        bytes_left = (length_reg == '0) ? 32'd1 : length_reg;
        block_left = '0;
        sum_lo     = 17'd1;
        sum_hi     = '0;
        emit_byte(HdrCmf, 1'b0);
        emit_byte(HdrFlg, 1'b0);
        in_stream = 1'b1;
      end

      // stored block head: final flag, len and nlen little endian
      if (block_left == '0) begin
        len = (bytes_left > 32'(BlockMax)) ? 32'(BlockMax) : bytes_left;
        emit_byte((bytes_left == len) ? 8'd1 : 8'd0, 1'b0);
        emit_byte(len[7:0], 1'b0);
        emit_byte(len[15:8], 1'b0);
        emit_byte(~len[7:0], 1'b0);
        emit_byte(~len[15:8], 1'b0);
        block_left = len[15:0];
      end

      // payload passes through, adler sums kept reduced
      emit_byte(b, 1'b0);
      sum_lo = sum_lo + 17'(b);
      if (sum_lo >= AdlerMod) sum_lo = sum_lo - AdlerMod;
      sum_hi = sum_hi + sum_lo;
      if (sum_hi >= AdlerMod) sum_hi = sum_hi - AdlerMod;
      block_left = block_left - 16'd1;
      bytes_left = bytes_left - 32'd1;

      // end of stream: checksum big endian, then rearm
      if (bytes_left == '0) begin
        emit_byte(sum_hi[15:8], 1'b0);
        emit_byte(sum_hi[7:0], 1'b0);
        emit_byte(sum_lo[15:8], 1'b0);
        emit_byte(sum_lo[7:0], 1'b1);
        in_stream  = 1'b0;
        block_left = '0;
        sum_lo     = 17'd1;
        sum_hi     = '0;
      end

      step_bytes[step_bytes.size() - 1].run_last = 1'b1;
      foreach (step_bytes[i]) frame_due.push_back(step_bytes[i]);
    endfunction

    task flag_mismatch(string msg);
      mismatches++;
      $display("mismatch at %0t: %s", $time, msg);
    endtask

    // one accepted result against the oldest expected byte
    task check_out(logic [7:0] ob, logic rl, logic sd);
      frame_byte_t want;
      if (frame_due.size() == 0) begin
        flag_mismatch($sformatf("byte %02h with nothing expected", ob));
      end else begin
        want = frame_due.pop_front();
        if (ob !== want.out_byte)
          flag_mismatch($sformatf("out_byte %02h, expected %02h", ob, want.out_byte));
        if (rl !== want.run_last)
          flag_mismatch($sformatf("run_last %b, expected %b on byte %02h",
                                  rl, want.run_last, want.out_byte));
        if (sd !== want.stream_done)
          flag_mismatch($sformatf("stream_done %b, expected %b on byte %02h",
                                  sd, want.stream_done, want.out_byte));
      end
    endtask

    function int unsigned bytes_to_close();
      return in_stream ? int'(bytes_left) : 0;
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i;
  logic        push;
  logic        full;
  logic [7:0]  payload_byte_i;
  logic        pop;
  logic        empty;
  logic [7:0]  out_byte_o;
  logic        run_last_o;
  logic        stream_done_o;

  bit gaps_on;
  bit stall_on;
  int unsigned quiet_cycles;

  zlib_frame_board board = new();

  zlib_stored_stream_framer_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .push           (push),
    .full           (full),
    .payload_byte_i (payload_byte_i),
    .pop            (pop),
    .empty          (empty),
    .out_byte_o     (out_byte_o),
    .run_last_o     (run_last_o),
    .stream_done_o  (stream_done_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // transfer monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) board.length_reg = cfg_data_i;
      if (push && !full) board.take_payload(payload_byte_i);
      if (pop && !empty) board.check_out(out_byte_o, run_last_o, stream_done_o);
      if ((cfg_valid_i && cfg_ready_o) || (push && !full) || (pop && !empty)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QuietLimit) begin
        $display("timeout: no transfer for %0d cycles", QuietLimit);
        $display("** zlib_stored_stream_framer_unit: FAILED **");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // result side with random stall bursts
  initial begin
    pop <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_on && $urandom_range(0, 7) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 16) - 1) @(posedge clk_i);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // mostly random bytes with the extremes favoured
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // one payload transfer, optionally followed by an idle burst
  task automatic send_byte(input logic [7:0] b);
    push           <= 1'b1;
    payload_byte_i <= b;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  endtask

  // hold the sender until every expected byte has been popped
  task automatic wait_quiet();
    push <= 1'b0;
    @(posedge clk_i);
    while (board.frame_due.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_length(input logic [31:0] v);
    wait_quiet();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int unsigned sent;
    int unsigned len;
    int unsigned n;

    rst_ni         <= 1'b0;
    cfg_valid_i    <= 1'b0;
    cfg_data_i     <= '0;
    push           <= 1'b0;
    payload_byte_i <= '0;
    gaps_on      = 1'b0;
    stall_on     = 1'b0;
    quiet_cycles = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single byte stream at the reset length
    send_byte(8'h00);

    // zero length behaves as one
    write_length(32'd0);
    send_byte(8'hFF);

    // short stream over the byte extremes
    write_length(32'd3);
    send_byte(8'h80);
    send_byte(8'h7F);
    send_byte(8'h55);

    // length written mid-stream only applies to the following stream
    write_length(32'd5);
    send_byte(8'hAA);
    send_byte(8'h01);
    write_length(32'd2);
    send_byte(8'h3C);
    send_byte(8'hC3);
    send_byte(8'h10);
    send_byte(8'hFE);
    send_byte(8'h00);

    // random phases: whole streams, sometimes left open across a rewrite
    sent = 0;
    while (sent < RandomBytes) begin
      gaps_on  = ($urandom_range(0, 3) != 0);
      stall_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) == 0) len = 0;
      else if ($urandom_range(0, 4) == 0) len = $urandom_range(25, 70);
      else len = $urandom_range(1, 24);
      n = ((len == 0) ? 1 : len) * $urandom_range(1, 3);
      if ($urandom_range(0, 3) == 0) n += $urandom_range(1, (len == 0) ? 1 : len);
      if (n > RandomBytes - sent) n = RandomBytes - sent;
      write_length(len);
      repeat (n) send_byte(pick_byte());
      sent += n;
    end

    // last part without idling: close any open stream first
    gaps_on  = 1'b0;
    stall_on = 1'b0;
    wait_quiet();
    repeat (board.bytes_to_close()) send_byte(pick_byte());

    // largest length: first block flagged not final, stream left open
    write_length(32'hFFFF_FFFF);
    repeat (6) send_byte(pick_byte());

    // drain
    push <= 1'b0;
    @(posedge clk_i);
    while (board.frame_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (board.mismatches == 0) begin
      $display("** zlib_stored_stream_framer_unit: PASSED **");
    end else begin
      $display("** zlib_stored_stream_framer_unit: FAILED **");
    end
    $finish;
  end

endmodule
